[src/ddo_pkg.sv]
package ddo_pkg;

  localparam int TICKS_LOG2_DEF   = 11;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int ATAN_ENTRIES     = 30;
  localparam int DIV_BITS         = 30;

  localparam logic [15:0] CIRC_RESET       = 16'd100;
  localparam logic [15:0] HALF_TRACK_RESET = 16'd350;

  localparam logic [29:0] PI_Q28       = 30'd843314857;
  localparam logic [29:0] PI_LIMIT     = 30'd843314858;
  localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  localparam logic REG_CIRC       = 1'b0;
  localparam logic REG_HALF_TRACK = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SCALE, S_HEAD, S_CHECK, S_DIV, S_ROT, S_CORDIC, S_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic scale;
    logic head;
    logic check;
    logic div_step;
    logic rot;
    logic cordic_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic cordic_last;
    logic out_busy;
  } dp_status_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'h3243F6A8;
      5'd1:  a = 30'h1DAC6705;
      5'd2:  a = 30'h0FADBAFC;
      5'd3:  a = 30'h07F56EA6;
      5'd4:  a = 30'h03FEAB76;
      5'd5:  a = 30'h01FFD55B;
      5'd6:  a = 30'h00FFFAAA;
      5'd7:  a = 30'h007FFF55;
      5'd8:  a = 30'h003FFFEA;
      5'd9:  a = 30'h001FFFFD;
      5'd10: a = 30'h000FFFFF;
      5'd11: a = 30'h0007FFFF;
      5'd12: a = 30'h0003FFFF;
      5'd13: a = 30'h0001FFFF;
      5'd14: a = 30'h0000FFFF;
      5'd15: a = 30'h00007FFF;
      5'd16: a = 30'h00003FFF;
      5'd17: a = 30'h00001FFF;
      5'd18: a = 30'h00000FFF;
      5'd19: a = 30'h000007FF;
      5'd20: a = 30'h000003FF;
      5'd21: a = 30'h000001FF;
      5'd22: a = 30'h000000FF;
      5'd23: a = 30'h0000007F;
      5'd24: a = 30'h0000003F;
      5'd25: a = 30'h0000001F;
      5'd26: a = 30'h0000000F;
      5'd27: a = 30'h00000007;
      5'd28: a = 30'h00000003;
      5'd29: a = 30'h00000001;
      default: a = 30'h0;
    endcase
    return a;
  endfunction

endpackage

[src/ddo_ctrl.sv]
module ddo_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  ddo_pkg::dp_status_t status,
  output ddo_pkg::dp_cmd_t    cmd
);
  import ddo_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_HEAD;
      end
      S_HEAD: begin
        cmd.head   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_ROT;
      end
      S_ROT: begin
        cmd.rot    = 1'b1;
        state_next = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (status.cordic_last) state_next = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!status.out_busy || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[src/ddo_datapath.sv]
module ddo_datapath #(
  parameter int TICKS_PER_REV_LOG2 = ddo_pkg::TICKS_LOG2_DEF,
  parameter int CORDIC_STEPS       = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                wheel_side,
  input  logic signed [31:0]  encoder_position,
  input  ddo_pkg::dp_cmd_t    cmd,
  input  logic                out_ready,
  output ddo_pkg::dp_status_t status,
  output logic signed [31:0]  heading_change,
  output logic signed [31:0]  travel_distance,
  output logic signed [31:0]  displacement_x,
  output logic signed [31:0]  displacement_y,
  output logic                angle_saturated,
  output logic                out_valid
);
  import ddo_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam logic [4:0]  LAST_CORDIC = 5'(NSTEPS - 1);
  localparam logic [4:0]  LAST_DIV    = 5'(DIV_BITS - 1);
  localparam logic [60:0] ROUND_HALF  = 61'(1) << (TICKS_PER_REV_LOG2 - 1);

  logic [15:0] circ, half_track;
  logic signed [31:0] last_left, last_right, left_dist, right_dist;

  logic        side;
  logic        delta_neg;
  logic [32:0] delta_mag;
  logic [48:0] prod;
  logic        diff_neg, diff_zero, ovf, clipped;
  logic [49:0] num;
  logic signed [31:0] mean, theta;
  logic [16:0] rem;
  logic [29:0] quo;
  logic signed [49:0] x0, x, y;
  logic signed [33:0] z;
  logic [4:0]  cnt;

  // combinational helpers
  logic signed [32:0] delta, diff, sum;
  logic [32:0] diff_mag;
  logic [60:0] scaled;
  logic signed [31:0] wheel_dist;
  logic [16:0] den;
  logic [46:0] limit;
  logic signed [61:0] gain_prod;
  logic [17:0] trial;
  logic        trial_ge;
  logic [29:0] theta_mag;
  logic signed [31:0] theta_s;
  logic signed [33:0] z0;
  logic signed [49:0] dx, dy;

  function automatic logic signed [31:0] to_q12(input logic signed [49:0] v);
    logic signed [49:0] t;
    logic signed [33:0] s;
    t = v + 50'sd32768;
    s = 34'(t >>> 16);
    if (s > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (s < -34'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  always_comb begin
    delta    = {encoder_position[31], encoder_position}
             - (wheel_side ? {last_right[31], last_right} : {last_left[31], last_left});
    scaled   = ({prod, 12'b0} + ROUND_HALF) >> TICKS_PER_REV_LOG2;
    if (delta_neg) begin
      wheel_dist = (scaled >= 61'h80000000) ? 32'sh80000000 : 32'(-scaled);
    end else begin
      wheel_dist = (scaled >= 61'h80000000) ? 32'sh7FFFFFFF : scaled[31:0];
    end
    diff     = {right_dist[31], right_dist} - {left_dist[31], left_dist};
    diff_mag = diff[32] ? 33'(-diff) : diff;
    sum      = {right_dist[31], right_dist} + {left_dist[31], left_dist};
    den      = {half_track, 1'b0};
    limit    = PI_LIMIT * den;
    gain_prod = mean * $signed({2'b0, INV_GAIN_Q30});
    trial    = {rem, quo[29]};
    trial_ge = trial >= {1'b0, den};
    theta_mag = diff_zero ? 30'd0 : (ovf ? PI_Q28 : quo);
    theta_s  = diff_neg ? -$signed({2'b0, theta_mag}) : $signed({2'b0, theta_mag});
    z0       = {theta_s, 2'b0};
    dx       = y >>> cnt;
    dy       = x >>> cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      circ       <= CIRC_RESET;
      half_track <= HALF_TRACK_RESET;
      last_left  <= '0;
      last_right <= '0;
      left_dist  <= '0;
      right_dist <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_CIRC) circ <= cfg_data;
        else half_track <= cfg_data;
      end
      if (cmd.load_in) begin
        if (wheel_side) last_right <= encoder_position;
        else last_left <= encoder_position;
      end
      if (cmd.scale) begin
        if (side) right_dist <= wheel_dist;
        else left_dist <= wheel_dist;
      end
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      side      <= wheel_side;
      delta_neg <= delta[32];
      delta_mag <= delta[32] ? 33'(-delta) : delta;
    end
    if (cmd.mul) prod <= delta_mag * circ;
    if (cmd.head) begin
      diff_neg  <= diff[32];
      diff_zero <= (diff == '0);
      num       <= {1'b0, diff_mag, 16'b0} + {34'b0, half_track};
      mean      <= 32'((sum + {32'b0, sum[32]}) >>> 1);
    end
    if (cmd.check) begin
      ovf <= num >= {3'b0, limit};
      rem <= num[46:30];
      quo <= num[29:0];
      x0  <= 50'(gain_prod >>> 14);
    end
    if (cmd.div_step) begin
      rem <= trial_ge ? 17'(trial - {1'b0, den}) : trial[16:0];
      quo <= {quo[28:0], trial_ge};
    end
    if (cmd.rot) begin
      theta   <= theta_s;
      clipped <= !diff_zero && ovf;
      // quarter turn first when the angle is beyond half pi
      if (z0 > $signed({3'b0, HALF_PI_Q30})) begin
        x <= '0;
        y <= x0;
        z <= z0 - $signed({3'b0, HALF_PI_Q30});
      end else if (z0 < -$signed({3'b0, HALF_PI_Q30})) begin
        x <= '0;
        y <= -x0;
        z <= z0 + $signed({3'b0, HALF_PI_Q30});
      end else begin
        x <= x0;
        y <= '0;
        z <= z0;
      end
    end
    if (cmd.cordic_step) begin
      if (!z[33]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - $signed({4'b0, atan_q30(cnt)});
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + $signed({4'b0, atan_q30(cnt)});
      end
    end
    if (cmd.check || cmd.rot) cnt <= '0;
    else if (cmd.div_step || cmd.cordic_step) cnt <= cnt + 5'd1;
    if (cmd.load_out) begin
      heading_change  <= theta;
      travel_distance <= mean;
      displacement_x  <= to_q12(x);
      displacement_y  <= to_q12(y);
      angle_saturated <= clipped;
    end
  end

  assign status.div_last    = (cnt == LAST_DIV);
  assign status.cordic_last = (cnt == LAST_CORDIC);
  assign status.out_busy    = out_valid;

endmodule

[src/differential_drive_odometry_step.sv]
// an input transaction passes through load, multiply, scale, heading and range check states,
// the 30-step heading divider, the quarter-turn rotation and the one-iteration-per-cycle CORDIC
// loop before the result is registered at the output; one item in flight at a time
// a finished result waits in the output register while the next item is taken
// reset: synchronous, clears wheel history and distances, restores register defaults
module differential_drive_odometry_step #(
  parameter int TICKS_PER_REV_LOG2 = ddo_pkg::TICKS_LOG2_DEF,
  parameter int CORDIC_STEPS       = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               wheel_side,
  input  logic signed [31:0] encoder_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] heading_change,
  output logic signed [31:0] travel_distance,
  output logic signed [31:0] displacement_x,
  output logic signed [31:0] displacement_y,
  output logic               angle_saturated
);
  import ddo_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ddo_datapath #(
    .TICKS_PER_REV_LOG2 (TICKS_PER_REV_LOG2),
    .CORDIC_STEPS       (CORDIC_STEPS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .wheel_side       (wheel_side),
    .encoder_position (encoder_position),
    .cmd              (cmd),
    .out_ready        (out_ready),
    .status           (status),
    .heading_change   (heading_change),
    .travel_distance  (travel_distance),
    .displacement_x   (displacement_x),
    .displacement_y   (displacement_y),
    .angle_saturated  (angle_saturated),
    .out_valid        (out_valid)
  );

endmodule
